// File: hdl/union_find_edge_filter_defines.svh
// ---------------------------------------------------------------------------
// union find edge filter assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_EDGE_FILTER_DEFINES_SVH
`define UNION_FIND_EDGE_FILTER_DEFINES_SVH

`ifndef SYNTH
`define UFEF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UFEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UFEF_ASSERT_SAME(lbl, ante, cons, msg)
`define UFEF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/ufef_pkg.sv
// ---------------------------------------------------------------------------
// ufef_pkg
// shared widths, codes and the sequencer control store
// ---------------------------------------------------------------------------
`default_nettype none

package ufef_pkg;

  localparam int LABEL_W = 8;
  localparam int RANK_W  = 4;
  localparam int KEPT_W  = 8;
  localparam int VC_W    = 9;
  localparam int STAT_W  = 2;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [KEPT_W-1:0]  kept_t;
  typedef logic [VC_W-1:0]    vcount_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [3:0]         step_t;
  typedef logic [2:0]         op_t;
  typedef logic [2:0]         cond_t;

  localparam rank_t   RANK_MAX  = 4'd15;
  localparam vcount_t VC_RESET  = 9'd256;

  localparam status_t ST_REJECT  = 2'd0;
  localparam status_t ST_KEPT    = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  localparam op_t OP_IDLE  = 3'd0;
  localparam op_t OP_START = 3'd1;
  localparam op_t OP_FIND  = 3'd2;
  localparam op_t OP_COMP  = 3'd3;
  localparam op_t OP_LINK  = 3'd4;
  localparam op_t OP_BUMP  = 3'd5;
  localparam op_t OP_DONE  = 3'd6;

  localparam cond_t C_NONE     = 3'd0;
  localparam cond_t C_ACCEPT   = 3'd1;
  localparam cond_t C_BAD      = 3'd2;
  localparam cond_t C_ROOT     = 3'd3;
  localparam cond_t C_AT_ROOT  = 3'd4;
  localparam cond_t C_NO_BUMP  = 3'd5;
  localparam cond_t C_OUT_FREE = 3'd6;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_START  = 4'd1;
  localparam step_t STEP_FIND_A = 4'd2;
  localparam step_t STEP_COMP_A = 4'd3;
  localparam step_t STEP_FIND_B = 4'd4;
  localparam step_t STEP_COMP_B = 4'd5;
  localparam step_t STEP_LINK   = 4'd6;
  localparam step_t STEP_BUMP   = 4'd7;
  localparam step_t STEP_DONE   = 4'd8;

  typedef struct packed {
    op_t   op;
    logic  sel_b;
    cond_t cond;
    step_t tgt;
    logic  hold;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w.op    = OP_IDLE;
    w.sel_b = 1'b0;
    w.cond  = C_NONE;
    w.tgt   = STEP_IDLE;
    w.hold  = 1'b0;
    case (step)
      STEP_IDLE: begin
        w.cond = C_ACCEPT;
        w.tgt  = STEP_START;
        w.hold = 1'b1;
      end
      STEP_START: begin
        w.op   = OP_START;
        w.cond = C_BAD;
        w.tgt  = STEP_DONE;
      end
      STEP_FIND_A: begin
        w.op   = OP_FIND;
        w.cond = C_ROOT;
        w.tgt  = STEP_COMP_A;
        w.hold = 1'b1;
      end
      STEP_COMP_A: begin
        w.op   = OP_COMP;
        w.cond = C_AT_ROOT;
        w.tgt  = STEP_FIND_B;
        w.hold = 1'b1;
      end
      STEP_FIND_B: begin
        w.op    = OP_FIND;
        w.sel_b = 1'b1;
        w.cond  = C_ROOT;
        w.tgt   = STEP_COMP_B;
        w.hold  = 1'b1;
      end
      STEP_COMP_B: begin
        w.op    = OP_COMP;
        w.sel_b = 1'b1;
        w.cond  = C_AT_ROOT;
        w.tgt   = STEP_LINK;
        w.hold  = 1'b1;
      end
      STEP_LINK: begin
        w.op   = OP_LINK;
        w.cond = C_NO_BUMP;
        w.tgt  = STEP_DONE;
      end
      STEP_BUMP: begin
        w.op = OP_BUMP;
      end
      STEP_DONE: begin
        w.op   = OP_DONE;
        w.cond = C_OUT_FREE;
        w.tgt  = STEP_IDLE;
        w.hold = 1'b1;
      end
      default: begin
        w.cond = C_NONE;
        w.tgt  = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ufef_ifs.sv
// ---------------------------------------------------------------------------
// ufef channel interfaces
// edge and result channels with valid / ready transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface ufef_edge_if;
  import ufef_pkg::*;
  logic   valid;
  logic   ready;
  label_t vertex_a;
  label_t vertex_b;
  logic   new_graph;

  modport source (output valid, output vertex_a, output vertex_b, output new_graph,
                  input ready);
  modport sink (input valid, input vertex_a, input vertex_b, input new_graph,
                output ready);
endinterface

interface ufef_result_if;
  import ufef_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  kept_t   kept_count;

  modport source (output valid, output status, output kept_count, input ready);
  modport sink (input valid, input status, input kept_count, output ready);
endinterface

`default_nettype wire

// File: hdl/union_find_edge_filter.sv
// ---------------------------------------------------------------------------
// union find edge filter
// spanning-tree edge filter over a rank / path-compressed disjoint-set store.
// edges: one edge per transfer, two labels and a new_graph flag; results:
// status (rejected, kept, invalid label) and the kept count since new_graph.
// cfg_we / cfg_data write vertex_count; the user writes it only while the
// block is idle, which the block itself does not enforce. each edge runs a
// small control program: accept, start, per endpoint a root walk and a
// compression pass, join, a rank bump on equal ranks, result load; the
// parent / rank memory gives one read per cycle. an invalid label goes
// straight from start to the result load. one edge at a time; the next edge is
// taken while the previous result still waits in the output register.
// reset (and new_graph) drops every entry's valid bit, so all vertices read
// as singletons at once; reset also returns vertex_count to 256.
// a stalled receiver holds the result; the sequencer waits in its last step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "union_find_edge_filter_defines.svh"

module union_find_edge_filter #(
  parameter int MAX_VERTICES = 256
) (
  input  wire                    clk,
  input  wire                    rst,
  ufef_edge_if.sink              edges,
  ufef_result_if.source          results,
  input  wire                    cfg_we,
  input  wire ufef_pkg::vcount_t cfg_data
);
  import ufef_pkg::*;

  localparam int DEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam vcount_t LIMIT = vcount_t'(DEPTH);

  typedef logic [AW-1:0] addr_t;
  typedef struct packed {
    rank_t rank;
    addr_t parent;
  } entry_t;

  entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid;

  vcount_t vertex_count;
  step_t   pc;
  step_t   pc_next;
  ucode_t  cw;
  logic    cond_true;

  addr_t   va, vb, cur, ra, rb;
  addr_t   cur_next;
  rank_t   rka, rkb;
  logic    bad;
  kept_t   kept;
  status_t status_q;

  entry_t  rd_raw;
  logic    rd_hit;
  addr_t   rparent;
  rank_t   rrank;
  addr_t   root_sel;

  logic    we;
  addr_t   waddr;
  entry_t  wdata;
  logic    accept;
  logic    clear;
  logic    bad_in;
  logic    out_free;

  assign accept   = edges.valid && edges.ready;
  assign clear    = accept && edges.new_graph;
  assign out_free = !results.valid || results.ready;
  assign bad_in   = ({1'b0, edges.vertex_a} >= vertex_count)
                 || ({1'b0, edges.vertex_a} >= LIMIT)
                 || ({1'b0, edges.vertex_b} >= vertex_count)
                 || ({1'b0, edges.vertex_b} >= LIMIT);

  assign edges.ready = (pc == STEP_IDLE);

  assign cw       = ucode_rom(pc);
  assign rparent  = rd_hit ? rd_raw.parent : cur;
  assign rrank    = rd_hit ? rd_raw.rank : '0;
  assign root_sel = cw.sel_b ? rb : ra;

  // jump condition
  always_comb begin
    case (cw.cond)
      C_ACCEPT:   cond_true = accept;
      C_BAD:      cond_true = bad;
      C_ROOT:     cond_true = (rparent == cur);
      C_AT_ROOT:  cond_true = (cur == root_sel);
      C_NO_BUMP:  cond_true = (ra == rb) || (rka != rkb);
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_next = cw.tgt;
    end else if (cw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  // datapath control
  always_comb begin
    cur_next = cur;
    we       = 1'b0;
    waddr    = cur;
    wdata    = '{rank: rrank, parent: root_sel};
    case (cw.op)
      OP_START: begin
        cur_next = va;
      end
      OP_FIND: begin
        if (rparent == cur) begin
          cur_next = cw.sel_b ? vb : va;
        end else begin
          cur_next = rparent;
        end
      end
      OP_COMP: begin
        if (cur == root_sel) begin
          cur_next = vb;
        end else begin
          we       = 1'b1;
          cur_next = rparent;
        end
      end
      OP_LINK: begin
        if (ra != rb) begin
          we = 1'b1;
          if (rka <= rkb) begin
            waddr = ra;
            wdata = '{rank: rka, parent: rb};
          end else begin
            waddr = rb;
            wdata = '{rank: rkb, parent: ra};
          end
        end
      end
      OP_BUMP: begin
        we    = 1'b1;
        waddr = rb;
        wdata = '{rank: (rkb == RANK_MAX) ? RANK_MAX : rkb + rank_t'(1), parent: rb};
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  // parent / rank memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[cur_next];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
    if (rst) begin
      rd_hit <= 1'b0;
    end else begin
      rd_hit <= valid[cur_next];
    end
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= STEP_IDLE;
      vertex_count <= VC_RESET;
      kept         <= '0;
      results.valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (clear) begin
        kept <= '0;
      end else if (cw.op == OP_LINK && ra != rb) begin
        kept <= kept + kept_t'(1);
      end
      if (cw.op == OP_DONE && out_free) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (accept) begin
      va  <= edges.vertex_a[AW-1:0];
      vb  <= edges.vertex_b[AW-1:0];
      bad <= bad_in;
    end
    if (cw.op == OP_FIND && rparent == cur) begin
      if (cw.sel_b) begin
        rb  <= cur;
        rkb <= rrank;
      end else begin
        ra  <= cur;
        rka <= rrank;
      end
    end
    if (cw.op == OP_START) begin
      status_q <= ST_INVALID;
    end else if (cw.op == OP_LINK) begin
      status_q <= (ra != rb) ? ST_KEPT : ST_REJECT;
    end
    if (cw.op == OP_DONE && out_free) begin
      results.status     <= status_q;
      results.kept_count <= kept;
    end
  end

  `UFEF_ASSERT_NEXT(a_accept_start, accept, pc == STEP_START, "accepted edge did not start")
  `UFEF_ASSERT_NEXT(a_kept_step, (cw.op == OP_LINK) && (ra != rb), kept == $past(kept) + 8'd1, "kept count did not advance on a join")
  `UFEF_ASSERT_SAME(a_comp_no_clash, (cw.op == OP_COMP) && we, cur_next != cur, "compression read collides with write")
  `UFEF_ASSERT_NEXT(a_bad_status, (cw.op == OP_START) && bad, status_q == ST_INVALID && pc == STEP_DONE, "invalid label not flagged")

endmodule

`default_nettype wire
